// ===== src/pareto_frontier_insert_macros.svh =====
// ----------------------------------------------------------------------------
// pareto frontier insert assertion macros
// shared property wrappers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef PARETO_FRONTIER_INSERT_MACROS_SVH
`define PARETO_FRONTIER_INSERT_MACROS_SVH

// same-cycle implication
`define PFI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pareto frontier insert check failed");

// next-cycle implication
`define PFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pareto frontier insert check failed");

`endif

// ===== src/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// pfi_pkg
// types, widths and codes shared by the pareto frontier insert block
// ----------------------------------------------------------------------------
package pfi_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIVE_W   = $clog2(CAPACITY + 2);
    localparam int BEAM_W   = 7;
    localparam int CMP_W    = (LIVE_W > BEAM_W) ? LIVE_W : BEAM_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 64;
    localparam int LEVEL_W = 6;
    localparam int COST_W  = 31;
    localparam int OUTC_W  = 3;
    localparam int OCNT_W  = 7;
    localparam int DROP_W  = 32;

    localparam int IN_TDATA_W  = ((KEY_W + LEVEL_W + COST_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 1 + KIND_W;
    localparam int OUT_TDATA_W = ((OCNT_W + OCNT_W + DROP_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = OUTC_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic [OUTC_W-1:0] OUT_STORED  = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_DROPPED = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_TRIMMED = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_FULL    = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_CLEARED = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] level;
        logic [COST_W-1:0]  cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   mode;
        entry_t entry;
    } item_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [OCNT_W-1:0] removed_count;
        logic [OCNT_W-1:0] entry_count;
        logic [DROP_W-1:0] dropped_total;
    } result_t;

    typedef struct packed {
        logic  start;
        item_t item;
    } ctl_req_t;

    typedef struct packed {
        logic    idle;
        logic    done;
        result_t result;
    } ctl_rsp_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== src/pfi_entry_ram.sv =====
// ----------------------------------------------------------------------------
// pfi_entry_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfi_entry_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfi_ctrl
// sequencer: clear, domination scan, placement, beam maximum scans and eviction
// ----------------------------------------------------------------------------
module pfi_ctrl
    import pfi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BEAM_W-1:0] beam_limit,
    input  ctl_req_t          req,
    input  logic              res_take,
    output ctl_rsp_t          rsp,
    output ram_req_t          ram,
    input  entry_t            ram_rdata
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_BEAM_CHK = 3'd3;
    localparam logic [2:0] ST_MAX_SCAN = 3'd4;
    localparam logic [2:0] ST_EVICT    = 3'd5;
    localparam logic [2:0] ST_FINAL    = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    function automatic logic [DROP_W-1:0] sat_add(input logic [DROP_W-1:0] a,
                                                  input logic [DROP_W-1:0] b);
        logic [DROP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DROP_W] ? {DROP_W{1'b1}} : s[DROP_W-1:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    item_t               item_reg, item_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] kill_reg, kill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DROP_W-1:0]   drops_reg, drops_next;

    logic                issue_reg, issue_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]    pipe_idx_reg, pipe_idx_next;

    logic                hit_reg, hit_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic                staged_reg, staged_next;
    logic                worst_found_reg, worst_found_next;
    logic [IDX_W-1:0]    worst_idx_reg, worst_idx_next;
    logic [COST_W-1:0]   worst_cost_reg, worst_cost_next;
    logic [LIVE_W-1:0]   trimmed_reg, trimmed_next;
    logic                ev_found_reg, ev_found_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic [OUTC_W-1:0]   outcome_reg, outcome_next;
    logic [LIVE_W-1:0]   res_rem_reg, res_rem_next;

    logic                slot_v;
    logic                same_key;
    logic                old_dom;
    logic                new_dom;
    logic                last_beat;
    logic [CMP_W-1:0]    live_cmp;
    logic [LIVE_W-1:0]   rem_total;

    assign slot_v    = valid_reg[pipe_idx_reg];
    assign same_key  = slot_v && (ram_rdata.kind == item_reg.entry.kind)
                       && (ram_rdata.key == item_reg.entry.key);
    assign old_dom   = same_key && (ram_rdata.level <= item_reg.entry.level)
                       && (ram_rdata.cost <= item_reg.entry.cost);
    assign new_dom   = same_key && (item_reg.entry.level <= ram_rdata.level)
                       && (item_reg.entry.cost <= ram_rdata.cost);
    assign last_beat = pipe_vld_reg && (pipe_idx_reg == LAST_IDX);
    assign live_cmp  = CMP_W'(count_reg) + CMP_W'(staged_reg);
    assign rem_total = LIVE_W'(removed_reg) + trimmed_reg;

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        valid_next       = valid_reg;
        kill_next        = kill_reg;
        count_next       = count_reg;
        drops_next       = drops_reg;
        hit_next         = hit_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        removed_next     = removed_reg;
        staged_next      = staged_reg;
        worst_found_next = worst_found_reg;
        worst_idx_next   = worst_idx_reg;
        worst_cost_next  = worst_cost_reg;
        trimmed_next     = trimmed_reg;
        ev_found_next    = ev_found_reg;
        ev_idx_next      = ev_idx_reg;
        outcome_next     = outcome_reg;
        res_rem_next     = res_rem_reg;

        // slot read pipeline
        issue_next    = issue_reg;
        addr_next     = addr_reg;
        pipe_vld_next = issue_reg;
        pipe_idx_next = addr_reg;
        if (issue_reg) begin
            if (addr_reg == LAST_IDX) begin
                issue_next = 1'b0;
            end else begin
                addr_next = addr_reg + 1'b1;
            end
        end

        ram       = '0;
        ram.re    = issue_reg;
        ram.raddr = addr_reg;
        ram.wdata = item_reg.entry;

        unique case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    item_next = req.item;
                    if (req.item.mode == MODE_CLEAR) begin
                        valid_next   = '0;
                        count_next   = '0;
                        outcome_next = OUT_CLEARED;
                        res_rem_next = '0;
                        state_next   = ST_EMIT;
                    end else begin
                        hit_next        = 1'b0;
                        free_found_next = 1'b0;
                        removed_next    = '0;
                        kill_next       = '0;
                        issue_next      = 1'b1;
                        addr_next       = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pipe_vld_reg) begin
                    if (old_dom) begin
                        hit_next = 1'b1;
                    end
                    if (new_dom) begin
                        kill_next[pipe_idx_reg] = 1'b1;
                        removed_next = removed_reg + 1'b1;
                    end
                    if (!free_found_reg && (!slot_v || new_dom)) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pipe_idx_reg;
                    end
                end
                if (last_beat) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                if (hit_reg) begin
                    drops_next   = sat_add(drops_reg, DROP_W'(1));
                    outcome_next = OUT_DROPPED;
                    res_rem_next = '0;
                    state_next   = ST_EMIT;
                end else begin
                    valid_next    = valid_reg & ~kill_reg;
                    drops_next    = sat_add(drops_reg, DROP_W'(removed_reg));
                    trimmed_next  = '0;
                    ev_found_next = 1'b0;
                    if (free_found_reg) begin
                        valid_next[free_idx_reg] = 1'b1;
                        count_next  = count_reg - removed_reg + 1'b1;
                        ram.we      = 1'b1;
                        ram.waddr   = free_idx_reg;
                        staged_next = 1'b0;
                    end else begin
                        count_next  = count_reg - removed_reg;
                        staged_next = 1'b1;
                    end
                    state_next = ST_BEAM_CHK;
                end
            end
            ST_BEAM_CHK: begin
                if ((beam_limit != '0) && (live_cmp > CMP_W'(beam_limit))) begin
                    worst_found_next = 1'b0;
                    issue_next       = 1'b1;
                    addr_next        = '0;
                    state_next       = ST_MAX_SCAN;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_MAX_SCAN: begin
                if (pipe_vld_reg && slot_v
                    && (!worst_found_reg || (ram_rdata.cost >= worst_cost_reg))) begin
                    worst_found_next = 1'b1;
                    worst_idx_next   = pipe_idx_reg;
                    worst_cost_next  = ram_rdata.cost;
                end
                if (last_beat) begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                priority if (staged_reg && (!worst_found_reg
                             || (item_reg.entry.cost >= worst_cost_reg))) begin
                    // the pending entry is the most expensive one
                    staged_next  = 1'b0;
                    trimmed_next = trimmed_reg + 1'b1;
                    state_next   = ST_BEAM_CHK;
                end else if (worst_found_reg) begin
                    valid_next[worst_idx_reg] = 1'b0;
                    count_next   = count_reg - 1'b1;
                    trimmed_next = trimmed_reg + 1'b1;
                    if (!ev_found_reg || (worst_idx_reg < ev_idx_reg)) begin
                        ev_found_next = 1'b1;
                        ev_idx_next   = worst_idx_reg;
                    end
                    state_next = ST_BEAM_CHK;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (staged_reg && !ev_found_reg) begin
                    outcome_next = OUT_FULL;
                    res_rem_next = '0;
                end else begin
                    if (staged_reg) begin
                        // lowest free slot is the lowest evicted one
                        valid_next[ev_idx_reg] = 1'b1;
                        count_next = count_reg + 1'b1;
                        ram.we     = 1'b1;
                        ram.waddr  = ev_idx_reg;
                    end
                    outcome_next = (trimmed_reg != '0) ? OUT_TRIMMED : OUT_STORED;
                    res_rem_next = rem_total;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            drops_reg    <= '0;
            issue_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            drops_reg    <= drops_next;
            issue_reg    <= issue_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        kill_reg        <= kill_next;
        addr_reg        <= addr_next;
        pipe_idx_reg    <= pipe_idx_next;
        hit_reg         <= hit_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        removed_reg     <= removed_next;
        staged_reg      <= staged_next;
        worst_found_reg <= worst_found_next;
        worst_idx_reg   <= worst_idx_next;
        worst_cost_reg  <= worst_cost_next;
        trimmed_reg     <= trimmed_next;
        ev_found_reg    <= ev_found_next;
        ev_idx_reg      <= ev_idx_next;
        outcome_reg     <= outcome_next;
        res_rem_reg     <= res_rem_next;
    end

    assign rsp.idle                 = (state_reg == ST_IDLE);
    assign rsp.done                 = (state_reg == ST_EMIT);
    assign rsp.result.outcome       = outcome_reg;
    assign rsp.result.removed_count = OCNT_W'(res_rem_reg);
    assign rsp.result.entry_count   = OCNT_W'(count_reg);
    assign rsp.result.dropped_total = drops_reg;

endmodule

// ===== src/pareto_frontier_insert.sv =====
// ----------------------------------------------------------------------------
// pareto_frontier_insert
// bounded pareto frontier with domination filter, beam trimming and clear
//
// channel   dir   handshake                        payload
// s_axis    in    s_axis_tvalid / s_axis_tready    mode, kind, key, level, cost
// m_axis    out   m_axis_tvalid / m_axis_tready    outcome, counts, drop total
// cfg       in    cfg_we                           beam_limit
//
// an insert runs one pass over the entry ram, at one slot per cycle on its
// single read port, then placement
// a dominated insert skips beam check and placement
// each beam eviction adds a maximum pass over the entry ram
// a clear skips the scans; the slot valid flags are flops, so reset is at once
// the next beat is taken as soon as the result sits in the output register
// ----------------------------------------------------------------------------
`include "pareto_frontier_insert_macros.svh"

module pareto_frontier_insert
    import pfi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // set_key, level, cost, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode, item_kind
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // removed_count, entry_count, dropped_total, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // outcome
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  logic                   cfg_we,
    input  logic [BEAM_W-1:0]      cfg_wdata
);

    localparam int LEVEL_LO = KEY_W;
    localparam int COST_LO  = KEY_W + LEVEL_W;

    logic [BEAM_W-1:0] beam_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg, m_result_next;
    ctl_req_t          req;
    ctl_rsp_t          rsp;
    ram_req_t          ram;
    entry_t            ram_rdata;
    logic              out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_reg <= '0;
        end else if (cfg_we) begin
            beam_reg <= cfg_wdata;
        end
    end

    assign s_axis_tready          = rsp.idle;
    assign req.start              = s_axis_tvalid && s_axis_tready;
    assign req.item.mode          = s_axis_tuser[0];
    assign req.item.entry.kind    = s_axis_tuser[KIND_W:1];
    assign req.item.entry.key     = s_axis_tdata[KEY_W-1:0];
    assign req.item.entry.level   = s_axis_tdata[LEVEL_LO +: LEVEL_W];
    assign req.item.entry.cost    = s_axis_tdata[COST_LO +: COST_W];

    assign out_free = !m_valid_reg || m_axis_tready;

    pfi_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beam_limit (beam_reg),
        .req        (req),
        .res_take   (out_free),
        .rsp        (rsp),
        .ram        (ram),
        .ram_rdata  (ram_rdata)
    );

    pfi_entry_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (rsp.done && out_free) begin
            m_valid_next  = 1'b1;
            m_result_next = rsp.result;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_result_reg.outcome;
    assign m_axis_tdata  = OUT_TDATA_W'({m_result_reg.dropped_total,
                                         m_result_reg.entry_count,
                                         m_result_reg.removed_count});

    `PFI_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PFI_ASSERT_NOW(a_no_removal, aclk, aresetn, m_valid_reg && (m_result_reg.outcome == OUT_DROPPED || m_result_reg.outcome == OUT_FULL || m_result_reg.outcome == OUT_CLEARED), m_result_reg.removed_count == '0)
    `PFI_ASSERT_NOW(a_clear_empties, aclk, aresetn, m_valid_reg && m_result_reg.outcome == OUT_CLEARED, m_result_reg.entry_count == '0)
    `PFI_ASSERT_NOW(a_result_from_work, aclk, aresetn, $rose(m_valid_reg), !$past(s_axis_tready))

endmodule
